FILE: rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

FILE: rtl/core/srtt_pkg.sv
package srtt_pkg;

  localparam int unsigned TableDepth  = 256;
  localparam int unsigned MaxTerminal = 999;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_RM_NWK  = 3'd2,
    CMD_FREE    = 3'd3,
    CMD_LOOKUP  = 3'd4,
    CMD_RAISE   = 3'd5,
    CMD_LOWER   = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [13:0] network_no;
    logic [9:0]  terminal_no;
    logic [15:0] location_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_location;
    logic [9:0]  free_terminal;
    logic [8:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [13:0] network;
    logic [9:0]  terminal;
    logic [15:0] use_count;
    logic [15:0] location;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_ACT_RD,
    S_ACT,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SCAN_RD,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       we;
    logic       re;
  } mem_ctl_t;

endpackage

FILE: rtl/core/srtt_mem.sv
module srtt_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                 clk,
  input  srtt_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]        waddr,
  input  srtt_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output srtt_pkg::entry_t     rdata
);
  import srtt_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/core/sorted_refcount_terminal_table.sv
// lookup runs a binary search over the held entries; add, remove and remove network
// then shift the moved entries in turn; raise, lower and find free walk the entries in turn
// throughput: one command at a time; busy stays high until the result strobe
// the table memory has one read and one write port, which sets the shifting speed
// synchronous active-low reset empties the table; the receiver cannot stall results
module sorted_refcount_terminal_table #(
  parameter int unsigned TABLE_DEPTH  = srtt_pkg::TableDepth,
  parameter int unsigned MAX_TERMINAL = srtt_pkg::MaxTerminal
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  srtt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output srtt_pkg::out_item_t  out_item
);
  import srtt_pkg::*;
`include "assert_macros.svh"

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;

  state_t          state_r, state_nxt;
  in_item_t        req_r, req_nxt;
  logic [CW-1:0]   held_r, held_nxt;
  logic [CW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [9:0]      next_r, next_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [15:0]     floc_r, floc_nxt;
  logic [9:0]      free_r, free_nxt;
  logic            out_valid_r, out_valid_nxt;

  mem_ctl_t        mctl;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;

  srtt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .ctl(mctl), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [CW-1:0] mid;
  logic [23:0]   skey, rkey;
  logic          hit;

  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign rkey = {rdata.network, rdata.terminal};
  assign skey = (req_r.cmd == CMD_RM_NWK || req_r.cmd == CMD_FREE) ?
                {req_r.network_no, 10'd0} : {req_r.network_no, req_r.terminal_no};
  assign hit  = (lo_r < held_r) && (rkey == skey);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    idx_r    <= idx_nxt;
    next_r   <= next_nxt;
    status_r <= status_nxt;
    floc_r   <= floc_nxt;
    free_r   <= free_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    held_nxt = held_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    idx_nxt = idx_r;
    next_nxt = next_r;
    status_nxt = status_r;
    floc_nxt = floc_r;
    free_nxt = free_r;
    out_valid_nxt = 1'b0;
    mctl = '0;
    waddr = idx_r[AW-1:0];
    raddr = idx_r[AW-1:0];
    wdata = rdata;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_item;
          status_nxt = ST_OK;
          floc_nxt = '0;
          free_nxt = '0;
          lo_nxt = '0;
          hi_nxt = held_r;
          idx_nxt = '0;
          next_nxt = 10'd1;
          case (in_item.cmd)
            CMD_CLEAR: begin
              held_nxt = '0;
              state_nxt = S_DONE;
            end
            CMD_RAISE, CMD_LOWER: state_nxt = S_SCAN_RD;
            default: state_nxt = S_BS_RD;
          endcase
        end
      end
      S_BS_RD: begin
        if (lo_r < hi_r) begin
          raddr = mid[AW-1:0];
          mctl.re = 1'b1;
          state_nxt = S_BS_CMP;
        end else begin
          state_nxt = S_ACT_RD;
        end
      end
      S_BS_CMP: begin
        if (rkey < skey) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_BS_RD;
      end
      S_ACT_RD: begin
        raddr = lo_r[AW-1:0];
        mctl.re = 1'b1;
        idx_nxt = lo_r;
        state_nxt = S_ACT;
      end
      S_ACT: begin
        state_nxt = S_DONE;
        waddr = lo_r[AW-1:0];
        case (req_r.cmd)
          CMD_ADD: begin
            if (hit) begin
              if (rdata.use_count != 16'hFFFF) begin
                wdata.use_count = rdata.use_count + 16'd1;
                mctl.we = 1'b1;
              end
            end else if (held_r >= CW'(TABLE_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              idx_nxt = held_r;
              state_nxt = S_INS_RD;
            end
          end
          CMD_REMOVE: begin
            if (!hit) begin
              status_nxt = ST_NOT_FOUND;
            end else if (rdata.use_count >= 16'd2) begin
              wdata.use_count = rdata.use_count - 16'd1;
              mctl.we = 1'b1;
            end else begin
              hi_nxt = lo_r + 1'b1;
              state_nxt = S_DEL_RD;
            end
          end
          CMD_LOOKUP: begin
            if (hit) floc_nxt = rdata.location;
            else status_nxt = ST_NOT_FOUND;
          end
          CMD_RM_NWK: begin
            if (lo_r < held_r && rdata.network == req_r.network_no) begin
              lo_nxt = lo_r;
              idx_nxt = lo_r + 1'b1;
              hi_nxt = lo_r;
              state_nxt = S_SCAN_RD;
            end
          end
          CMD_FREE: begin
            if (lo_r >= held_r || rdata.network != req_r.network_no) begin
              free_nxt = next_r;
            end else if (rdata.terminal > next_r) begin
              free_nxt = next_r;
            end else if (rdata.terminal < next_r) begin
              free_nxt = 10'd1;
            end else if (32'(next_r) + 1 > MAX_TERMINAL) begin
              free_nxt = 10'd1;
            end else begin
              next_nxt = next_r + 10'd1;
              lo_nxt = lo_r + 1'b1;
              state_nxt = S_ACT_RD;
            end
          end
          default: ;
        endcase
      end
      S_INS_RD: begin
        if (idx_r > lo_r) begin
          raddr = AW'(idx_r - 1'b1);
          mctl.re = 1'b1;
          state_nxt = S_INS_WR;
        end else begin
          waddr = lo_r[AW-1:0];
          wdata.network = req_r.network_no;
          wdata.terminal = req_r.terminal_no;
          wdata.use_count = 16'd1;
          wdata.location = req_r.location_index;
          mctl.we = 1'b1;
          held_nxt = held_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        mctl.we = 1'b1;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_INS_RD;
      end
      S_DEL_RD: begin
        if (hi_r < held_r) begin
          raddr = hi_r[AW-1:0];
          mctl.re = 1'b1;
          state_nxt = S_DEL_WR;
        end else begin
          held_nxt = held_r - (hi_r - idx_r);
          state_nxt = S_DONE;
        end
      end
      S_DEL_WR: begin
        waddr = idx_r[AW-1:0];
        mctl.we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        hi_nxt = hi_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_SCAN_RD: begin
        if (idx_r < held_r) begin
          mctl.re = 1'b1;
          state_nxt = S_SCAN;
        end else if (req_r.cmd == CMD_RM_NWK) begin
          hi_nxt = idx_r;
          idx_nxt = lo_r;
          state_nxt = S_DEL_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        state_nxt = S_SCAN_RD;
        idx_nxt = idx_r + 1'b1;
        if (req_r.cmd == CMD_RM_NWK) begin
          if (rdata.network != req_r.network_no) begin
            hi_nxt = idx_r;
            idx_nxt = lo_r;
            state_nxt = S_DEL_RD;
          end
        end else if (rdata.location >= req_r.location_index) begin
          if (req_r.cmd == CMD_RAISE && rdata.location != 16'hFFFF) begin
            wdata.location = rdata.location + 16'd1;
            mctl.we = 1'b1;
          end else if (req_r.cmd == CMD_LOWER && rdata.location != 16'd0) begin
            wdata.location = rdata.location - 16'd1;
            mctl.we = 1'b1;
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item.status = status_r;
  assign out_item.found_location = floc_r;
  assign out_item.free_terminal = free_r;
  assign out_item.entry_count = 9'(held_r);

  `ASSERT_IMPL(a_held_range, clk, rst_n, 1'b1, held_r <= CW'(TABLE_DEPTH))
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, !busy)
endmodule
